[src/svm_pkg.sv]
// Shared types, codes and command/status bundles for the stack/register VM core.
package svm_pkg;

    // Default sizes handed to the top level parameters.
    localparam int STACK_DEPTH_DEF = 32;
    localparam int REG_COUNT_DEF   = 32;

    // Opcodes.
    localparam logic [7:0] OP_HALT    = 8'd0;
    localparam logic [7:0] OP_DISPLAY = 8'd1;
    localparam logic [7:0] OP_PRINTST = 8'd2;
    localparam logic [7:0] OP_PUSH    = 8'd3;
    localparam logic [7:0] OP_POP     = 8'd4;
    localparam logic [7:0] OP_MOV     = 8'd5;
    localparam logic [7:0] OP_CALL    = 8'd6;
    localparam logic [7:0] OP_RET     = 8'd7;
    localparam logic [7:0] OP_JMP     = 8'd8;
    localparam logic [7:0] OP_JZ      = 8'd9;
    localparam logic [7:0] OP_JPOS    = 8'd10;
    localparam logic [7:0] OP_JNEG    = 8'd11;
    localparam logic [7:0] OP_ADD     = 8'd12;
    localparam logic [7:0] OP_SUB     = 8'd13;
    localparam logic [7:0] OP_MUL     = 8'd14;
    localparam logic [7:0] OP_DIV     = 8'd15;

    // Result kinds.
    localparam logic [2:0] KIND_DONE    = 3'd0;
    localparam logic [2:0] KIND_DISPLAY = 3'd1;
    localparam logic [2:0] KIND_ENTRY   = 3'd2;
    localparam logic [2:0] KIND_HALTED  = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW = 3'd1;
    localparam logic [2:0] ERR_DIVZERO  = 3'd2;
    localparam logic [2:0] ERR_STK_OVF  = 3'd3;
    localparam logic [2:0] ERR_STK_UNF  = 3'd4;
    localparam logic [2:0] ERR_BAD_REG  = 3'd5;
    localparam logic [2:0] ERR_BAD_OP   = 3'd6;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_RDA, ST_RDB, ST_EXEC,
        ST_MULCHK, ST_DIV, ST_RDS, ST_PRINT, ST_PRD
    } state_t;

    typedef enum logic [2:0] {
        IP_HOLD, IP_ADD2, IP_ADD3, IP_LOAD_A, IP_LOAD_ST
    } ip_op_t;

    typedef enum logic [1:0] {SP_HOLD, SP_INC, SP_DEC} sp_op_t;
    typedef enum logic [1:0] {SW_RF, SW_RET, SW_ARITH} st_wsel_t;
    typedef enum logic {SR_TOP, SR_PJ} st_rsel_t;
    typedef enum logic {RW_B, RW_ST} rf_wsel_t;
    typedef enum logic {RR_A, RR_B} rf_rsel_t;
    typedef enum logic [1:0] {EV_NONE, EV_DISPLAY, EV_ENTRY} ev_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       rf_re;
        rf_rsel_t   rf_rsel;
        logic       rf_we;
        rf_wsel_t   rf_wsel;
        logic       st_re;
        st_rsel_t   st_rsel;
        logic       st_we;
        st_wsel_t   st_wsel;
        sp_op_t     sp_op;
        ip_op_t     ip_op;
        logic       stop_set;
        logic [2:0] stop_code;
        logic       emit;
        logic [2:0] emit_kind;
        logic [2:0] emit_code;
        ev_t        emit_val;
        logic       emit_last;
        logic       x_load;
        logic       y_load;
        logic       prod_load;
        logic       div_start;
        logic       print_init;
        logic       print_step;
    } svm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       out_free;
        logic       stopped;
        logic [2:0] stop_status;
        logic       at_end;
        logic [7:0] op;
        logic       a_ok;
        logic       b_ok;
        logic       sp_zero;
        logic       sp_full;
        logic       print_err;
        logic       print_fault;
        logic       print_done;
        logic       add_ovf;
        logic       sub_ovf;
        logic       mul_ovf;
        logic       div_zero;
        logic       div_ovf;
        logic       div_busy;
        logic       take;
    } svm_sts_t;

endpackage

[src/svm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[src/svm_ctrl.sv]
// Controller state machine that sequences each instruction through the datapath.
module svm_ctrl import svm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  svm_sts_t sts,
    output svm_cmd_t cmd
);

    typedef enum logic [3:0] {
        ACT_WAIT, ACT_STOPPED, ACT_END, ACT_FAIL, ACT_HALT, ACT_READ_A,
        ACT_PRINT, ACT_POP, ACT_MOV, ACT_CALL, ACT_JMP
    } act_t;

    state_t     state_reg, state_next;
    act_t       act;
    logic [2:0] act_code;
    logic       arith_op;
    logic       rega_op;

    // Error result that also stops the block.
    function automatic svm_cmd_t fail_cmd(svm_cmd_t c, logic [2:0] code);
        svm_cmd_t r;
        r = c;
        r.stop_set  = 1'b1;
        r.stop_code = code;
        r.emit      = 1'b1;
        r.emit_kind = KIND_ERROR;
        r.emit_code = code;
        r.emit_last = 1'b1;
        return r;
    endfunction

    // Plain step-done result.
    function automatic svm_cmd_t done_cmd(svm_cmd_t c);
        svm_cmd_t r;
        r = c;
        r.emit      = 1'b1;
        r.emit_kind = KIND_DONE;
        r.emit_code = ERR_NONE;
        r.emit_last = 1'b1;
        return r;
    endfunction

    assign arith_op = (sts.op >= OP_ADD) && (sts.op <= OP_DIV);
    assign rega_op  = (sts.op == OP_DISPLAY) || (sts.op == OP_PUSH) ||
                      (sts.op == OP_POP) || (sts.op == OP_MOV);

    // Decode of a freshly accepted instruction, in check order.
    always_comb begin
        act      = ACT_WAIT;
        act_code = ERR_NONE;
        if (!sts.out_free) begin
            act = ACT_WAIT;
        end else if (sts.stopped) begin
            act = ACT_STOPPED;
        end else if (sts.at_end) begin
            act = ACT_END;
        end else if (sts.op > OP_DIV) begin
            act      = ACT_FAIL;
            act_code = ERR_BAD_OP;
        end else if (sts.op == OP_HALT) begin
            act = ACT_HALT;
        end else if ((rega_op && !sts.a_ok) || (arith_op && (!sts.a_ok || !sts.b_ok))) begin
            act      = ACT_FAIL;
            act_code = ERR_BAD_REG;
        end else if (sts.op == OP_DISPLAY || sts.op == OP_PUSH || arith_op) begin
            act = ACT_READ_A;
        end else if (sts.op == OP_PRINTST) begin
            act = ACT_PRINT;
        end else if (sts.op == OP_POP || sts.op == OP_RET || sts.op == OP_JZ ||
                     sts.op == OP_JPOS || sts.op == OP_JNEG) begin
            if (sts.sp_zero) begin
                act      = ACT_FAIL;
                act_code = ERR_STK_UNF;
            end else begin
                act = ACT_POP;
            end
        end else if (sts.op == OP_MOV) begin
            act = ACT_MOV;
        end else if (sts.op == OP_CALL) begin
            if (sts.sp_full) begin
                act      = ACT_FAIL;
                act_code = ERR_STK_OVF;
            end else begin
                act = ACT_CALL;
            end
        end else begin
            act = ACT_JMP;
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (act)
                    ACT_WAIT:   state_next = ST_DECODE;
                    ACT_READ_A: state_next = ST_RDA;
                    ACT_PRINT:  state_next = ST_PRINT;
                    ACT_POP:    state_next = ST_RDS;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_RDA: begin
                if (sts.out_free) begin
                    state_next = arith_op ? ST_RDB : ST_IDLE;
                end
            end
            ST_RDB: state_next = ST_EXEC;
            ST_EXEC: begin
                if (sts.op == OP_MUL) begin
                    state_next = ST_MULCHK;
                end else if (sts.out_free) begin
                    if (sts.op == OP_DIV && !sts.div_zero && !sts.div_ovf) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MULCHK: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_DIV: begin
                if (!sts.div_busy && sts.out_free) state_next = ST_IDLE;
            end
            ST_RDS: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            ST_PRINT: begin
                if (!sts.print_done) begin
                    state_next = ST_PRD;
                end else if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRD: begin
                if (sts.out_free) state_next = ST_PRINT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output logic: datapath commands for each state.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_DECODE: begin
                unique case (act)
                    ACT_WAIT: begin
                    end
                    ACT_STOPPED: begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = (sts.stop_status == ERR_NONE) ? KIND_HALTED
                                                                      : KIND_ERROR;
                        cmd.emit_code = sts.stop_status;
                        cmd.emit_last = 1'b1;
                    end
                    ACT_END, ACT_HALT: begin
                        cmd.stop_set  = 1'b1;
                        cmd.stop_code = ERR_NONE;
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_HALTED;
                        cmd.emit_code = ERR_NONE;
                        cmd.emit_last = 1'b1;
                    end
                    ACT_FAIL: cmd = fail_cmd(cmd, act_code);
                    ACT_READ_A: begin
                        cmd.rf_re   = 1'b1;
                        cmd.rf_rsel = RR_A;
                    end
                    ACT_PRINT: begin
                        cmd.print_init = 1'b1;
                        cmd.ip_op      = sts.print_err ? IP_HOLD : IP_ADD2;
                    end
                    ACT_POP: begin
                        cmd.st_re   = 1'b1;
                        cmd.st_rsel = SR_TOP;
                    end
                    ACT_MOV: begin
                        cmd.rf_we   = 1'b1;
                        cmd.rf_wsel = RW_B;
                        cmd.ip_op   = IP_ADD3;
                        cmd         = done_cmd(cmd);
                    end
                    ACT_CALL: begin
                        cmd.st_we   = 1'b1;
                        cmd.st_wsel = SW_RET;
                        cmd.sp_op   = SP_INC;
                        cmd.ip_op   = IP_LOAD_A;
                        cmd         = done_cmd(cmd);
                    end
                    default: begin
                        cmd.ip_op = IP_LOAD_A;
                        cmd       = done_cmd(cmd);
                    end
                endcase
            end
            ST_RDA: begin
                if (sts.out_free) begin
                    if (sts.op == OP_DISPLAY) begin
                        cmd.ip_op     = IP_ADD2;
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_DISPLAY;
                        cmd.emit_code = ERR_NONE;
                        cmd.emit_val  = EV_DISPLAY;
                        cmd.emit_last = 1'b1;
                    end else if (sts.op == OP_PUSH) begin
                        if (sts.sp_full) begin
                            cmd = fail_cmd(cmd, ERR_STK_OVF);
                        end else begin
                            cmd.st_we   = 1'b1;
                            cmd.st_wsel = SW_RF;
                            cmd.sp_op   = SP_INC;
                            cmd.ip_op   = IP_ADD2;
                            cmd         = done_cmd(cmd);
                        end
                    end else begin
                        cmd.x_load  = 1'b1;
                        cmd.rf_re   = 1'b1;
                        cmd.rf_rsel = RR_B;
                    end
                end
            end
            ST_RDB: cmd.y_load = 1'b1;
            ST_EXEC: begin
                if (sts.op == OP_MUL) begin
                    cmd.prod_load = 1'b1;
                end else if (sts.out_free) begin
                    if (sts.op == OP_DIV) begin
                        if (sts.div_zero) begin
                            cmd = fail_cmd(cmd, ERR_DIVZERO);
                        end else if (sts.div_ovf) begin
                            cmd = fail_cmd(cmd, ERR_OVERFLOW);
                        end else begin
                            cmd.div_start = 1'b1;
                        end
                    end else if ((sts.op == OP_ADD) ? sts.add_ovf : sts.sub_ovf) begin
                        cmd = fail_cmd(cmd, ERR_OVERFLOW);
                    end else if (sts.sp_full) begin
                        cmd = fail_cmd(cmd, ERR_STK_OVF);
                    end else begin
                        cmd.st_we   = 1'b1;
                        cmd.st_wsel = SW_ARITH;
                        cmd.sp_op   = SP_INC;
                        cmd.ip_op   = IP_ADD3;
                        cmd         = done_cmd(cmd);
                    end
                end
            end
            ST_MULCHK, ST_DIV: begin
                if (sts.out_free && !(state_reg == ST_DIV && sts.div_busy)) begin
                    if (state_reg == ST_MULCHK && sts.mul_ovf) begin
                        cmd = fail_cmd(cmd, ERR_OVERFLOW);
                    end else if (sts.sp_full) begin
                        cmd = fail_cmd(cmd, ERR_STK_OVF);
                    end else begin
                        cmd.st_we   = 1'b1;
                        cmd.st_wsel = SW_ARITH;
                        cmd.sp_op   = SP_INC;
                        cmd.ip_op   = IP_ADD3;
                        cmd         = done_cmd(cmd);
                    end
                end
            end
            ST_RDS: begin
                if (sts.out_free) begin
                    cmd.sp_op = SP_DEC;
                    if (sts.op == OP_POP) begin
                        cmd.rf_we   = 1'b1;
                        cmd.rf_wsel = RW_ST;
                        cmd.ip_op   = IP_ADD2;
                    end else if (sts.op == OP_RET) begin
                        cmd.ip_op = IP_LOAD_ST;
                    end else begin
                        cmd.ip_op = sts.take ? IP_LOAD_A : IP_ADD2;
                    end
                    cmd = done_cmd(cmd);
                end
            end
            ST_PRINT: begin
                if (!sts.print_done) begin
                    cmd.st_re   = 1'b1;
                    cmd.st_rsel = SR_PJ;
                end else if (sts.out_free) begin
                    if (sts.print_fault) begin
                        cmd = fail_cmd(cmd, ERR_STK_UNF);
                    end else begin
                        cmd = done_cmd(cmd);
                    end
                end
            end
            ST_PRD: begin
                if (sts.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = KIND_ENTRY;
                    cmd.emit_code  = ERR_NONE;
                    cmd.emit_val   = EV_ENTRY;
                    cmd.emit_last  = 1'b0;
                    cmd.print_step = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[src/svm_dp.sv]
// Datapath: register file, stack, pointers, arithmetic units and result register.
module svm_dp import svm_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int REG_COUNT   = REG_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  svm_cmd_t           cmd,
    output svm_sts_t           sts,
    input  logic [7:0]         in_req_type,
    input  logic signed [31:0] in_operand_a,
    input  logic signed [31:0] in_operand_b,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic [4:0]         m_position,
    output logic signed [31:0] m_value,
    output logic [31:0]        m_next_ip,
    output logic [2:0]         m_error_code,
    output logic               m_last
);

    localparam int RW = $clog2(REG_COUNT);
    localparam int SW = $clog2(STACK_DEPTH);

    // Latched instruction and operands.
    logic [7:0]         op_reg;
    logic signed [31:0] a_reg, b_reg, x_reg, y_reg;
    logic signed [63:0] prod_reg;

    // Architectural state.
    logic [31:0]      ip_reg, ip_next;
    logic [SW:0]      sp_reg, sp_next;
    logic [15:0]      plen_reg;
    logic             stopped_reg;
    logic [2:0]       status_reg;
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic             rf_rvalid_reg;

    // Print walk.
    logic [SW:0] pj_reg, pcnt_reg, pcnt_init;
    logic        perr_reg, print_err;

    // Divider.
    logic [31:0] dv_rem_reg, dv_quo_reg, dv_dvs_reg;
    logic [5:0]  dv_cnt_reg;
    logic        dv_neg_reg;
    logic [32:0] dv_rem_s;
    logic [33:0] dv_diff;
    logic [31:0] quo_s;

    logic               m_valid_reg;
    logic               out_free;
    logic [RW-1:0]      rf_raddr;
    logic [31:0]        rf_rdata, rf_data, rf_wdata;
    logic [SW-1:0]      st_raddr;
    logic [31:0]        st_rdata, st_wdata;
    logic [SW:0]        sp_m1, pj_m1;
    logic signed [32:0] sum33, diff33;
    logic signed [31:0] arith_res;

    assign sp_m1    = sp_reg - 1'b1;
    assign pj_m1    = pj_reg - 1'b1;
    assign out_free = !m_valid_reg || m_ready;

    // Instruction latch and operand registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg <= in_req_type;
            a_reg  <= in_operand_a;
            b_reg  <= in_operand_b;
        end
        if (cmd.x_load)    x_reg    <= $signed(rf_data);
        if (cmd.y_load)    y_reg    <= $signed(rf_data);
        if (cmd.prod_load) prod_reg <= x_reg * y_reg;
    end

    // Register file memory; valid bits make unwritten registers read as zero.
    assign rf_raddr = (cmd.rf_rsel == RR_A) ? a_reg[RW-1:0] : b_reg[RW-1:0];
    assign rf_wdata = (cmd.rf_wsel == RW_B) ? b_reg : st_rdata;
    assign rf_data  = rf_rvalid_reg ? rf_rdata : 32'd0;

    svm_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
        .aclk  (aclk),
        .we    (cmd.rf_we),
        .waddr (a_reg[RW-1:0]),
        .wdata (rf_wdata),
        .re    (cmd.rf_re),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg  <= '0;
            rf_rvalid_reg <= 1'b0;
        end else begin
            if (cmd.rf_we) rf_valid_reg[a_reg[RW-1:0]] <= 1'b1;
            if (cmd.rf_re) rf_rvalid_reg <= rf_valid_reg[rf_raddr];
        end
    end

    // Arithmetic results.
    assign sum33  = {x_reg[31], x_reg} + {y_reg[31], y_reg};
    assign diff33 = {x_reg[31], x_reg} - {y_reg[31], y_reg};
    assign quo_s  = dv_neg_reg ? (32'd0 - dv_quo_reg) : dv_quo_reg;

    always_comb begin
        case (op_reg)
            OP_ADD:  arith_res = sum33[31:0];
            OP_SUB:  arith_res = diff33[31:0];
            OP_MUL:  arith_res = prod_reg[31:0];
            default: arith_res = quo_s;
        endcase
    end

    // Stack memory.
    assign st_raddr = (cmd.st_rsel == SR_TOP) ? sp_m1[SW-1:0] : pj_m1[SW-1:0];

    always_comb begin
        case (cmd.st_wsel)
            SW_RF:   st_wdata = rf_data;
            SW_RET:  st_wdata = ip_reg + 32'd2;
            default: st_wdata = arith_res;
        endcase
    end

    svm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (cmd.st_we),
        .waddr (sp_reg[SW-1:0]),
        .wdata (st_wdata),
        .re    (cmd.st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Restoring divider on magnitudes, one quotient bit per cycle.
    assign dv_rem_s = {dv_rem_reg, dv_quo_reg[31]};
    assign dv_diff  = {1'b0, dv_rem_s} - {2'b00, dv_dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_cnt_reg <= 6'd0;
        end else if (cmd.div_start) begin
            dv_rem_reg <= 32'd0;
            dv_quo_reg <= x_reg[31] ? (32'd0 - x_reg) : x_reg;
            dv_dvs_reg <= y_reg[31] ? (32'd0 - y_reg) : y_reg;
            dv_neg_reg <= x_reg[31] ^ y_reg[31];
            dv_cnt_reg <= 6'd32;
        end else if (dv_cnt_reg != 6'd0) begin
            dv_rem_reg <= dv_diff[33] ? dv_rem_s[31:0] : dv_diff[31:0];
            dv_quo_reg <= {dv_quo_reg[30:0], !dv_diff[33]};
            dv_cnt_reg <= dv_cnt_reg - 6'd1;
        end
    end

    // Print walk bounds: count clipped to the stack, fault when it exceeds it.
    assign print_err = a_reg > $signed(32'(sp_reg));
    assign pcnt_init = (a_reg[31] || a_reg == 32'sd0) ? '0 :
                       print_err ? sp_reg : a_reg[SW:0];

    always_ff @(posedge aclk) begin
        if (cmd.print_init) begin
            pj_reg   <= sp_reg;
            pcnt_reg <= pcnt_init;
            perr_reg <= print_err;
        end else if (cmd.print_step) begin
            pj_reg   <= pj_m1;
            pcnt_reg <= pcnt_reg - 1'b1;
        end
    end

    // Pointer next values.
    always_comb begin
        case (cmd.ip_op)
            IP_ADD2:    ip_next = ip_reg + 32'd2;
            IP_ADD3:    ip_next = ip_reg + 32'd3;
            IP_LOAD_A:  ip_next = a_reg;
            IP_LOAD_ST: ip_next = st_rdata;
            default:    ip_next = ip_reg;
        endcase
        case (cmd.sp_op)
            SP_INC:  sp_next = sp_reg + 1'b1;
            SP_DEC:  sp_next = sp_m1;
            default: sp_next = sp_reg;
        endcase
    end

    // Control state: pointers, stop flag, program length.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_reg      <= 32'd0;
            sp_reg      <= '0;
            stopped_reg <= 1'b0;
            status_reg  <= ERR_NONE;
            plen_reg    <= 16'd0;
        end else begin
            ip_reg <= ip_next;
            sp_reg <= sp_next;
            if (cmd.stop_set) begin
                stopped_reg <= 1'b1;
                status_reg  <= cmd.stop_code;
            end
            if (cfg_wr_en) plen_reg <= cfg_wr_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_kind       <= cmd.emit_kind;
            m_error_code <= cmd.emit_code;
            m_last       <= cmd.emit_last;
            m_next_ip    <= ip_next;
            case (cmd.emit_val)
                EV_DISPLAY: begin
                    m_position <= a_reg[4:0];
                    m_value    <= $signed(rf_data);
                end
                EV_ENTRY: begin
                    m_position <= 5'(pj_m1);
                    m_value    <= $signed(st_rdata);
                end
                default: begin
                    m_position <= 5'd0;
                    m_value    <= 32'sd0;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;

    // Status back to the controller.
    always_comb begin
        sts.out_free    = out_free;
        sts.stopped     = stopped_reg;
        sts.stop_status = status_reg;
        sts.at_end      = ip_reg >= 32'(plen_reg);
        sts.op          = op_reg;
        sts.a_ok        = $unsigned(a_reg) < 32'(REG_COUNT);
        sts.b_ok        = $unsigned(b_reg) < 32'(REG_COUNT);
        sts.sp_zero     = sp_reg == '0;
        sts.sp_full     = sp_reg >= (SW+1)'(STACK_DEPTH);
        sts.print_err   = print_err;
        sts.print_fault = perr_reg;
        sts.print_done  = pcnt_reg == '0;
        sts.add_ovf     = sum33[32] ^ sum33[31];
        sts.sub_ovf     = diff33[32] ^ diff33[31];
        sts.mul_ovf     = !((prod_reg[63:31] == '0) || (prod_reg[63:31] == '1));
        sts.div_zero    = y_reg == 32'sd0;
        sts.div_ovf     = (x_reg == INT_MIN) && (y_reg == -32'sd1);
        sts.div_busy    = dv_cnt_reg != 6'd0;
        case (op_reg)
            OP_JZ:   sts.take = st_rdata == 32'd0;
            OP_JPOS: sts.take = !st_rdata[31] && (st_rdata != 32'd0);
            default: sts.take = st_rdata[31];
        endcase
    end

endmodule

[src/stack_register_vm_core_unit.sv]
// Top level of the stack/register VM core: controller plus datapath.
//
// The fetcher sends one instruction per request on the s_ channel (opcode and
// two operand words). The core answers on the m_ channel with one or more
// results; the final one carries m_last, and m_next_ip tells the fetcher which
// address to supply next. The user must write program_length through cfg_wr_en
// and cfg_wr_data only while the core is idle; the core does not enforce it.
// Sequencing: halt, move, call, jump and requests that stop finish in decode;
// display and push read a register, pop, return and conditional jumps read the
// stack top, add/sub read both registers and then execute, multiply adds a
// product check and divide waits on the 32-step iterative divider. Print-stack
// emits each entry with one stack memory read and one result write.
// A new request is taken once the previous instruction has placed its final
// result in the output register, even while that result still waits.
// Reset clears the registers to zero, empties the stack, zeroes both pointers
// and program_length, and clears the stopped state. The register file is reset
// by valid bits, so no clearing pass is needed.
// When the receiver stalls, the result register holds and the core waits before
// producing the next result; no result is dropped.
module stack_register_vm_core_unit import svm_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int REG_COUNT   = REG_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_req_type,
    input  logic signed [31:0] s_operand_a,
    input  logic signed [31:0] s_operand_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic [4:0]         m_position,
    output logic signed [31:0] m_value,
    output logic [31:0]        m_next_ip,
    output logic [2:0]         m_error_code,
    output logic               m_last,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);

    svm_cmd_t cmd;
    svm_sts_t sts;

    // Instruction sequencer.
    svm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage and execution units.
    svm_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .REG_COUNT   (REG_COUNT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_req_type  (s_req_type),
        .in_operand_a (s_operand_a),
        .in_operand_b (s_operand_b),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_position   (m_position),
        .m_value      (m_value),
        .m_next_ip    (m_next_ip),
        .m_error_code (m_error_code),
        .m_last       (m_last)
    );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the stack/register VM core: random programs, predicted results.
module tb import svm_pkg::*; ();

    // One instruction request and one result, at the port widths.
    typedef struct {
        logic [7:0]  op;
        logic [31:0] opa;
        logic [31:0] opb;
    } instr_t;

    typedef struct {
        logic [2:0]  kind;
        logic [4:0]  pos;
        logic [31:0] val;
        logic [31:0] nip;
        logic [2:0]  err;
        logic        last;
    } vm_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_req_type;
    logic signed [31:0] s_operand_a;
    logic signed [31:0] s_operand_b;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_kind;
    logic [4:0]         m_position;
    logic signed [31:0] m_value;
    logic [31:0]        m_next_ip;
    logic [2:0]         m_error_code;
    logic               m_last;
    logic               cfg_wr_en;
    logic [15:0]        cfg_wr_data;

    stack_register_vm_core_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_position  (m_position),
        .m_value     (m_value),
        .m_next_ip   (m_next_ip),
        .m_error_code(m_error_code),
        .m_last      (m_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock with a period of 10.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Shadow machine state used to predict every result.
    logic signed [31:0] vm_regs [32];
    logic [31:0]        vm_stack [32];
    int                 vm_sp;
    logic [31:0]        vm_ip;
    logic               vm_stopped;
    logic [2:0]         vm_status;
    logic [15:0]        vm_plen;

    // Saved copy so that a rejected candidate leaves no trace.
    logic signed [31:0] sv_regs [32];
    logic [31:0]        sv_stack [32];
    int                 sv_sp;
    logic [31:0]        sv_ip;
    logic               sv_stopped;
    logic [2:0]         sv_status;

    instr_t     request_q [$];
    vm_result_t step_results [$];
    vm_result_t expected_results [$];

    int n_requests = 0;
    int n_results  = 0;
    int n_mismatch = 0;
    int max_depth;
    int max_burst;
    string end_mode;

    // Appends one result of the instruction being predicted.
    function automatic void post(logic [2:0] kind, logic [4:0] pos, logic [31:0] val,
                                 logic [2:0] err, logic last);
        vm_result_t r;
        r.kind = kind;
        r.pos  = pos;
        r.val  = val;
        r.nip  = vm_ip;
        r.err  = err;
        r.last = last;
        step_results.push_back(r);
    endfunction

    function automatic void stop_with(logic [2:0] code);
        vm_stopped = 1'b1;
        vm_status  = code;
        post(KIND_ERROR, 5'd0, 32'd0, code, 1'b1);
    endfunction

    function automatic bit reg_valid(logic [31:0] idx);
        return $signed(idx) >= 0 && $signed(idx) < 32;
    endfunction

    // Executes one instruction on the shadow state and collects its results.
    function automatic void execute_instr(instr_t it);
        longint sp64;
        longint x;
        longint y;
        longint r;
        logic signed [31:0] top;
        bit take;
        bit step_done;
        step_results.delete();
        step_done = 1'b1;
        if (vm_stopped) begin
            if (vm_status == ERR_NONE)
                post(KIND_HALTED, 5'd0, 32'd0, ERR_NONE, 1'b1);
            else
                post(KIND_ERROR, 5'd0, 32'd0, vm_status, 1'b1);
            return;
        end
        if (vm_ip >= {16'd0, vm_plen}) begin
            vm_stopped = 1'b1;
            vm_status  = ERR_NONE;
            post(KIND_HALTED, 5'd0, 32'd0, ERR_NONE, 1'b1);
            return;
        end
        case (it.op)
            OP_HALT: begin
                vm_stopped = 1'b1;
                vm_status  = ERR_NONE;
                post(KIND_HALTED, 5'd0, 32'd0, ERR_NONE, 1'b1);
                step_done = 1'b0;
            end
            OP_DISPLAY: begin
                if (!reg_valid(it.opa)) begin
                    stop_with(ERR_BAD_REG);
                end else begin
                    vm_ip = vm_ip + 32'd2;
                    post(KIND_DISPLAY, it.opa[4:0], vm_regs[it.opa[4:0]], ERR_NONE, 1'b1);
                end
                step_done = 1'b0;
            end
            OP_PRINTST: begin
                sp64 = vm_sp;
                if (sp64 - longint'($signed(it.opa)) < 0) begin
                    for (int j = vm_sp - 1; j >= 0; j--)
                        post(KIND_ENTRY, j[4:0], vm_stack[j], ERR_NONE, 1'b0);
                    stop_with(ERR_STK_UNF);
                end else begin
                    vm_ip = vm_ip + 32'd2;
                    for (longint j = sp64 - 1;
                         j >= sp64 - longint'($signed(it.opa)) && j >= 0; j--)
                        post(KIND_ENTRY, j[4:0], vm_stack[j], ERR_NONE, 1'b0);
                    post(KIND_DONE, 5'd0, 32'd0, ERR_NONE, 1'b1);
                end
                step_done = 1'b0;
            end
            OP_PUSH: begin
                if (!reg_valid(it.opa)) begin
                    stop_with(ERR_BAD_REG);
                    step_done = 1'b0;
                end else if (vm_sp >= 32) begin
                    stop_with(ERR_STK_OVF);
                    step_done = 1'b0;
                end else begin
                    vm_stack[vm_sp] = vm_regs[it.opa[4:0]];
                    vm_sp++;
                    vm_ip = vm_ip + 32'd2;
                end
            end
            OP_POP: begin
                if (!reg_valid(it.opa)) begin
                    stop_with(ERR_BAD_REG);
                    step_done = 1'b0;
                end else if (vm_sp == 0) begin
                    stop_with(ERR_STK_UNF);
                    step_done = 1'b0;
                end else begin
                    vm_sp--;
                    vm_regs[it.opa[4:0]] = vm_stack[vm_sp];
                    vm_ip = vm_ip + 32'd2;
                end
            end
            OP_MOV: begin
                if (!reg_valid(it.opa)) begin
                    stop_with(ERR_BAD_REG);
                    step_done = 1'b0;
                end else begin
                    vm_regs[it.opa[4:0]] = it.opb;
                    vm_ip = vm_ip + 32'd3;
                end
            end
            OP_CALL: begin
                if (vm_sp >= 32) begin
                    stop_with(ERR_STK_OVF);
                    step_done = 1'b0;
                end else begin
                    vm_stack[vm_sp] = vm_ip + 32'd2;
                    vm_sp++;
                    vm_ip = it.opa;
                end
            end
            OP_RET: begin
                if (vm_sp == 0) begin
                    stop_with(ERR_STK_UNF);
                    step_done = 1'b0;
                end else begin
                    vm_sp--;
                    vm_ip = vm_stack[vm_sp];
                end
            end
            OP_JMP: vm_ip = it.opa;
            OP_JZ, OP_JPOS, OP_JNEG: begin
                if (vm_sp == 0) begin
                    stop_with(ERR_STK_UNF);
                    step_done = 1'b0;
                end else begin
                    vm_sp--;
                    top = vm_stack[vm_sp];
                    if (it.op == OP_JZ)
                        take = (top == 0);
                    else if (it.op == OP_JPOS)
                        take = (top > 0);
                    else
                        take = (top < 0);
                    vm_ip = take ? it.opa : vm_ip + 32'd2;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                step_done = 1'b0;
                if (!reg_valid(it.opa) || !reg_valid(it.opb)) begin
                    stop_with(ERR_BAD_REG);
                end else begin
                    x = vm_regs[it.opa[4:0]];
                    y = vm_regs[it.opb[4:0]];
                    r = 0;
                    if (it.op == OP_ADD)
                        r = x + y;
                    else if (it.op == OP_SUB)
                        r = x - y;
                    else if (it.op == OP_MUL)
                        r = x * y;
                    else if (y != 0)
                        r = x / y;
                    if (it.op == OP_DIV && y == 0)
                        stop_with(ERR_DIVZERO);
                    else if (r > longint'(INT_MAX) || r < longint'(INT_MIN))
                        stop_with(ERR_OVERFLOW);
                    else if (vm_sp >= 32)
                        stop_with(ERR_STK_OVF);
                    else begin
                        vm_stack[vm_sp] = r[31:0];
                        vm_sp++;
                        vm_ip = vm_ip + 32'd3;
                        step_done = 1'b1;
                    end
                end
            end
            default: begin
                stop_with(ERR_BAD_OP);
                step_done = 1'b0;
            end
        endcase
        if (step_done)
            post(KIND_DONE, 5'd0, 32'd0, ERR_NONE, 1'b1);
    endfunction

    // Predicts a candidate; keeps it only if it may stop the machine or it does not.
    function automatic bit offer_instr(instr_t it, bit may_stop);
        bit keep;
        sv_regs    = vm_regs;
        sv_stack   = vm_stack;
        sv_sp      = vm_sp;
        sv_ip      = vm_ip;
        sv_stopped = vm_stopped;
        sv_status  = vm_status;
        execute_instr(it);
        keep = may_stop || (!vm_stopped && vm_ip < {16'd0, vm_plen});
        if (keep) begin
            request_q.push_back(it);
            foreach (step_results[i])
                expected_results.push_back(step_results[i]);
            if (vm_sp > max_depth)
                max_depth = vm_sp;
            if (step_results.size() > max_burst)
                max_burst = step_results.size();
        end else begin
            vm_regs    = sv_regs;
            vm_stack   = sv_stack;
            vm_sp      = sv_sp;
            vm_ip      = sv_ip;
            vm_stopped = sv_stopped;
            vm_status  = sv_status;
        end
        return keep;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 6))
            0: return INT_MAX;
            1: return INT_MIN;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    // Random well-formed instruction, weighted toward pushes and arithmetic.
    function automatic instr_t random_instr();
        instr_t it;
        int roll;
        roll   = $urandom_range(0, 99);
        it.opa = $urandom_range(0, 31);
        it.opb = $urandom_range(0, 31);
        if (roll < 22)      it.op = OP_PUSH;
        else if (roll < 32) begin
            it.op  = OP_MOV;
            it.opb = pick_value();
        end
        else if (roll < 48) it.op = OP_ADD + $urandom_range(0, 3);
        else if (roll < 55) it.op = OP_POP;
        else if (roll < 62) it.op = OP_JZ + $urandom_range(0, 2);
        else if (roll < 66) it.op = OP_CALL;
        else if (roll < 70) it.op = OP_RET;
        else if (roll < 74) it.op = OP_JMP;
        else if (roll < 84) it.op = OP_DISPLAY;
        else begin
            it.op = OP_PRINTST;
            case ($urandom_range(0, 3))
                0: it.opa = $urandom | 32'h8000_0000;
                1: it.opa = vm_sp;
                default: it.opa = $urandom_range(0, vm_sp);
            endcase
        end
        if (it.op inside {OP_CALL, OP_JMP, OP_JZ, OP_JPOS, OP_JNEG})
            it.opa = ($urandom_range(0, 1) == 0) ? vm_ip + $urandom_range(0, 12)
                                                 : $urandom_range(0, 2000);
        return it;
    endfunction

    function automatic instr_t wild_instr();
        instr_t it;
        it.op  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
        it.opa = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 40);
        it.opb = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 40);
        return it;
    endfunction

    function automatic instr_t make_instr(logic [7:0] op, logic [31:0] opa, logic [31:0] opb);
        instr_t it;
        it.op  = op;
        it.opa = opa;
        it.opb = opb;
        return it;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int     burst_left;
    int     gap_left;
    instr_t cur_req;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_req_type  <= '0;
            s_operand_a <= '0;
            s_operand_b <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else begin
            if (s_valid && s_ready)
                n_requests <= n_requests + 1;
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (request_q.size() > 0) begin
                    cur_req     = request_q.pop_front();
                    s_valid     <= 1'b1;
                    s_req_type  <= cur_req.op;
                    s_operand_a <= cur_req.opa;
                    s_operand_b <= cur_req.opb;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: own stall pattern, plus one long hold-off to back the core up.
    int  rx_cnt;
    int  hold_left;
    bit  hold_done;
    vm_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_cnt    <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            // Compare each accepted result with the oldest prediction.
            if (m_valid && m_ready) begin
                n_results <= n_results + 1;
                if (expected_results.size() == 0) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("unexpected result: kind %0d pos %0d value %h next_ip %h",
                                 m_kind, m_position, m_value, m_next_ip);
                end else begin
                    want = expected_results.pop_front();
                    if (m_kind !== want.kind || m_position !== want.pos ||
                        m_value !== want.val || m_next_ip !== want.nip ||
                        m_error_code !== want.err || m_last !== want.last) begin
                        n_mismatch <= n_mismatch + 1;
                        if (n_mismatch < 10) begin
                            $write("mismatch: expected kind %0d pos %0d value %h ip %h ",
                                   want.kind, want.pos, want.val, want.nip);
                            $display("err %0d last %0d, got %0d %0d %h %h %0d %0d",
                                     want.err, want.last, m_kind, m_position, m_value,
                                     m_next_ip, m_error_code, m_last);
                        end
                    end
                end
            end
            rx_cnt <= rx_cnt + 1;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (!hold_done && n_requests >= 45) begin
                hold_left <= 400;
                hold_done <= 1'b1;
                m_ready   <= 1'b0;
            end else if (rx_cnt[7:6] == 2'd0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    // Waits until the core has drained all requests and results.
    task automatic drain();
        while (request_q.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_length(logic [15:0] len);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        vm_plen = len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Main sequence: directed program, random phases, then one way of stopping.
    initial begin
        int  kept;
        bit  ok;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        max_depth   = 0;
        max_burst   = 0;
        foreach (vm_regs[i]) vm_regs[i] = '0;
        foreach (vm_stack[i]) vm_stack[i] = '0;
        vm_sp      = 0;
        vm_ip      = '0;
        vm_stopped = 1'b0;
        vm_status  = ERR_NONE;
        vm_plen    = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        write_length(16'hFFFF);

        // Directed: corner values, every non-stopping operation, deep and empty prints.
        ok = offer_instr(make_instr(OP_MOV, 0, INT_MAX), 0);
        ok = offer_instr(make_instr(OP_MOV, 1, INT_MIN), 0);
        ok = offer_instr(make_instr(OP_MOV, 2, 32'hFFFF_FFFF), 0);
        ok = offer_instr(make_instr(OP_MOV, 31, 7), 0);
        ok = offer_instr(make_instr(OP_DISPLAY, 0, 0), 0);
        ok = offer_instr(make_instr(OP_DISPLAY, 31, 0), 0);
        for (int r = 0; r < 4; r++)
            ok = offer_instr(make_instr(OP_PUSH, r, 0), 0);
        ok = offer_instr(make_instr(OP_PRINTST, 4, 0), 0);
        ok = offer_instr(make_instr(OP_PRINTST, 0, 0), 0);
        ok = offer_instr(make_instr(OP_PRINTST, INT_MIN, 0), 0);
        ok = offer_instr(make_instr(OP_ADD, 31, 2), 0);
        ok = offer_instr(make_instr(OP_SUB, 3, 31), 0);
        ok = offer_instr(make_instr(OP_MUL, 0, 2), 0);
        ok = offer_instr(make_instr(OP_DIV, 1, 31), 0);
        ok = offer_instr(make_instr(OP_POP, 5, 0), 0);
        ok = offer_instr(make_instr(OP_JNEG, vm_ip + 6, 0), 0);
        ok = offer_instr(make_instr(OP_JPOS, vm_ip + 4, 0), 0);
        ok = offer_instr(make_instr(OP_JZ, vm_ip + 8, 0), 0);
        ok = offer_instr(make_instr(OP_CALL, 1000, 0), 0);
        ok = offer_instr(make_instr(OP_RET, 0, 0), 0);
        ok = offer_instr(make_instr(OP_JMP, vm_ip + 20, 0), 0);

        // Random phases under different program lengths.
        for (int phase = 0; phase < 3; phase++) begin
            kept = 0;
            while (kept < 30)
                if (offer_instr(random_instr(), 0))
                    kept++;
            drain();
            if (phase == 0)
                write_length($urandom_range(3000, 65534));
            else if (phase == 1)
                write_length(16'hFFFF);
        end

        // Stop the machine once, then check that it stays stopped.
        case ($urandom_range(0, 2))
            0: begin
                end_mode = "halt";
                ok = offer_instr(make_instr(OP_HALT, $urandom, $urandom), 1);
            end
            1: begin
                end_mode = "fault";
                while (!vm_stopped)
                    ok = offer_instr(wild_instr(), 1);
            end
            default: begin
                end_mode = "end of program";
                write_length(16'd0);
                ok = offer_instr(random_instr(), 1);
            end
        endcase
        for (int i = 0; i < 15; i++)
            ok = offer_instr(wild_instr(), 1);
        drain();

        $display("Run covered %0d requests and %0d results; deepest stack %0d,",
                 n_requests, n_results, max_depth);
        $display("longest result burst %0d, stopped by %s.", max_burst, end_mode);
        if (n_mismatch == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[stack_register_vm_core_unit.f]
src/svm_pkg.sv
src/svm_ram.sv
src/svm_ctrl.sv
src/svm_dp.sv
src/stack_register_vm_core_unit.sv
tb/sv/tb.sv
